// ===== rtl/kpl_pkg.sv =====
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and constants of the keypad password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

  localparam int MAX_CHARS_DEF = 10;
  localparam int BUF_LEN       = 10;
  localparam int NUM_USERS     = 4;
  localparam int KEY_W         = 8;
  localparam int CNT_W         = 4;
  localparam int USER_W        = 2;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int PASS_HI_W     = 16;

  localparam logic [KEY_W-1:0] KEY_NONE       = 8'h00;
  localparam logic [KEY_W-1:0] KEY_USER_FIRST = 8'h31;  // '1'
  localparam logic [KEY_W-1:0] KEY_USER_LAST  = 8'h34;  // '4'
  localparam logic [KEY_W-1:0] KEY_ENTER      = 8'h45;  // 'E'
  localparam logic [KEY_W-1:0] KEY_CLEAR      = 8'h43;  // 'C'

  typedef logic [BUF_LEN-1:0][KEY_W-1:0] pass_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER1_LOW  = 8'd0,
    REG_USER1_HIGH = 8'd1,
    REG_USER2_LOW  = 8'd2,
    REG_USER2_HIGH = 8'd3,
    REG_USER3_LOW  = 8'd4,
    REG_USER3_HIGH = 8'd5,
    REG_USER4_LOW  = 8'd6,
    REG_USER4_HIGH = 8'd7
  } cfg_reg_t;

  // Reset passwords "1111", "91939", "666" and "12345", character 0 lowest.
  localparam logic [CFG_DATA_W-1:0] PASS1_RST = 64'd825307441;
  localparam logic [CFG_DATA_W-1:0] PASS2_RST = 64'd245672522041;
  localparam logic [CFG_DATA_W-1:0] PASS3_RST = 64'd3552822;
  localparam logic [CFG_DATA_W-1:0] PASS4_RST = 64'd228509037105;

  typedef struct packed {
    logic             entry_phase;
    logic             char_accepted;
    logic             buffer_cleared;
    logic [CNT_W-1:0] chars_entered;
    logic             verdict_valid;
    logic             access_granted;
  } kpl_result_t;

endpackage

// ===== rtl/kpl_pass_regs.sv =====
// ----------------------------------------------------------------------------
// kpl_pass_regs
// Password register file for the four users, written over the config port.
// ----------------------------------------------------------------------------
module kpl_pass_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output kpl_pkg::pass_t                pass_o [kpl_pkg::NUM_USERS]
);
  import kpl_pkg::*;

  logic [CFG_DATA_W-1:0] low_r  [NUM_USERS];
  logic [PASS_HI_W-1:0]  high_r [NUM_USERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r[0]  <= PASS1_RST;
      low_r[1]  <= PASS2_RST;
      low_r[2]  <= PASS3_RST;
      low_r[3]  <= PASS4_RST;
      high_r[0] <= '0;
      high_r[1] <= '0;
      high_r[2] <= '0;
      high_r[3] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_USER1_LOW:  low_r[0]  <= cfg_wdata;
        REG_USER1_HIGH: high_r[0] <= cfg_wdata[PASS_HI_W-1:0];
        REG_USER2_LOW:  low_r[1]  <= cfg_wdata;
        REG_USER2_HIGH: high_r[1] <= cfg_wdata[PASS_HI_W-1:0];
        REG_USER3_LOW:  low_r[2]  <= cfg_wdata;
        REG_USER3_HIGH: high_r[2] <= cfg_wdata[PASS_HI_W-1:0];
        REG_USER4_LOW:  low_r[3]  <= cfg_wdata;
        REG_USER4_HIGH: high_r[3] <= cfg_wdata[PASS_HI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int u = 0; u < NUM_USERS; u++) begin
      pass_o[u] = pass_t'({high_r[u], low_r[u]});
    end
  end

endmodule

// ===== rtl/kpl_entry_core.sv =====
// ----------------------------------------------------------------------------
// kpl_entry_core
// Login and entry state, buffer update and password compare for one item.
// ----------------------------------------------------------------------------
module kpl_entry_core #(
  parameter int MAX_CHARS = kpl_pkg::MAX_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [kpl_pkg::KEY_W-1:0] key,
  input  kpl_pkg::pass_t            pass_i [kpl_pkg::NUM_USERS],
  output kpl_pkg::kpl_result_t      res_o
);
  import kpl_pkg::*;

  logic              phase_r, phase_nxt;
  logic [USER_W-1:0] user_r, user_nxt;
  logic [KEY_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  pass_t             buf_r, buf_nxt;
  logic              accepted, cleared, verdict;

  always_comb begin
    phase_nxt = phase_r;
    user_nxt  = user_r;
    cnt_nxt   = cnt_r;
    buf_nxt   = buf_r;
    accepted  = 1'b0;
    cleared   = 1'b0;
    verdict   = 1'b0;
    cnt_inc   = cnt_r + CNT_W'(1);

    if (!phase_r) begin
      if (key >= KEY_USER_FIRST && key <= KEY_USER_LAST) begin
        user_nxt  = USER_W'(key - KEY_USER_FIRST);
        cnt_nxt   = '0;
        buf_nxt   = '0;
        phase_nxt = 1'b1;
      end
    end else if (key != KEY_NONE && prev_r == KEY_NONE) begin
      // Only a press edge counts during entry.
      case (key)
        KEY_ENTER: verdict = 1'b1;
        KEY_CLEAR: begin
          cnt_nxt = '0;
          buf_nxt = '0;
          cleared = 1'b1;
        end
        default: begin
          for (int k = 0; k < BUF_LEN; k++) begin
            if (cnt_r == CNT_W'(k)) buf_nxt[k] = key;
          end
          cnt_nxt  = cnt_inc;
          accepted = 1'b1;
          if (cnt_inc >= CNT_W'(MAX_CHARS)) verdict = 1'b1;
        end
      endcase
    end

    // The count is zero whenever the block awaits a user.
    res_o.chars_entered  = cnt_nxt;
    res_o.char_accepted  = accepted;
    res_o.buffer_cleared = cleared;
    res_o.verdict_valid  = verdict;
    res_o.access_granted = verdict && (buf_nxt == pass_i[user_r]);

    if (verdict) begin
      phase_nxt = 1'b0;
      cnt_nxt   = '0;
      buf_nxt   = '0;
    end
    res_o.entry_phase = phase_nxt;
    prev_nxt = key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      user_r  <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
      buf_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      user_r  <= user_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      buf_r   <= buf_nxt;
    end
  end

endmodule

// ===== rtl/keypad_password_lock_top.sv =====
// ----------------------------------------------------------------------------
// keypad_password_lock_top
// Four-user keypad combination lock, one keypad sample per item.
// ----------------------------------------------------------------------------
// Usage: each input item carries one keypad sample (0 when no key is down).
// Every accepted item yields exactly one result item with the phase, echo,
// clear flag, character count and, at the end of entry, the verdict.
// The sample is caught in an input register; the state update and the
// ten-character compare then run from the input register into the result
// register. One item is taken every cycle while in_stall is low.
// When the receiver stalls, the result register holds; one more item may
// sit in the input register, after which in_stall rises until the result
// is taken.
// Reset (synchronous, rst_n low) returns to awaiting a user with an empty
// buffer and loads the default passwords. The user must write passwords
// through the cfg_ port while no item is in flight; the block does not check.
// ----------------------------------------------------------------------------
module keypad_password_lock_top #(
  parameter int MAX_CHARS = kpl_pkg::MAX_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kpl_pkg::KEY_W-1:0]      in_key_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_entry_phase,
  output logic                           out_char_accepted,
  output logic                           out_buffer_cleared,
  output logic [kpl_pkg::CNT_W-1:0]      out_chars_entered,
  output logic                           out_verdict_valid,
  output logic                           out_access_granted,
  input  logic                           cfg_wr_en,
  input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kpl_pkg::*;

  logic              in_vld_r;
  logic [KEY_W-1:0]  key_r;
  logic              fire;
  logic              out_vld_r;
  kpl_result_t       res, res_r;
  pass_t             pass [NUM_USERS];

  assign fire     = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_r <= in_key_code;
    end
  end

  kpl_pass_regs u_pass_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pass_o    (pass)
  );

  kpl_entry_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_entry_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .key    (key_r),
    .pass_i (pass),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_entry_phase    = res_r.entry_phase;
  assign out_char_accepted  = res_r.char_accepted;
  assign out_buffer_cleared = res_r.buffer_cleared;
  assign out_chars_entered  = res_r.chars_entered;
  assign out_verdict_valid  = res_r.verdict_valid;
  assign out_access_granted = res_r.access_granted;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad password lock. Keypad samples are sent
// in random bursts while the receiver stalls on its own pattern. A behavioural
// lock in the bench predicts every result item, and each result is compared
// field by field. Passwords are rewritten between runs of login sessions,
// including the all-ones and all-zeros extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import kpl_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int NUM_PHASES   = 6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP    = {CFG_IDX_W{1'b1}};

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [KEY_W-1:0]      in_key_code = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  out_entry_phase;
  logic                  out_char_accepted;
  logic                  out_buffer_cleared;
  logic [CNT_W-1:0]      out_chars_entered;
  logic                  out_verdict_valid;
  logic                  out_access_granted;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  keypad_password_lock_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_phase    (out_entry_phase),
    .out_char_accepted  (out_char_accepted),
    .out_buffer_cleared (out_buffer_cleared),
    .out_chars_entered  (out_chars_entered),
    .out_verdict_valid  (out_verdict_valid),
    .out_access_granted (out_access_granted),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Behavioural copy of the lock.
  logic [CFG_DATA_W-1:0] pass_low  [NUM_USERS] = '{PASS1_RST, PASS2_RST, PASS3_RST, PASS4_RST};
  logic [PASS_HI_W-1:0]  pass_high [NUM_USERS] = '{default: '0};
  logic                  lock_entry = 1'b0;
  logic [USER_W-1:0]     lock_user  = '0;
  logic [KEY_W-1:0]      last_key   = KEY_NONE;
  logic [CNT_W-1:0]      typed_count = '0;
  pass_t                 typed_buf   = '0;

  cfg_reg_t low_reg  [NUM_USERS] = '{REG_USER1_LOW, REG_USER2_LOW, REG_USER3_LOW, REG_USER4_LOW};
  cfg_reg_t high_reg [NUM_USERS] =
    '{REG_USER1_HIGH, REG_USER2_HIGH, REG_USER3_HIGH, REG_USER4_HIGH};

  kpl_result_t lock_results [$];
  int          items_sent  = 0;
  int          results_seen = 0;
  int          mismatches  = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic pass_t stored_password(input logic [USER_W-1:0] user);
    return {pass_high[user], pass_low[user]};
  endfunction

  // Advances the lock by one keypad sample and returns the result it gives.
  function automatic kpl_result_t lock_step(input logic [KEY_W-1:0] key);
    kpl_result_t r;
    r = '0;
    if (!lock_entry) begin
      if (key >= KEY_USER_FIRST && key <= KEY_USER_LAST) begin
        lock_user   = USER_W'(key - KEY_USER_FIRST);
        typed_count = '0;
        typed_buf   = '0;
        lock_entry  = 1'b1;
      end
    end else if (key != KEY_NONE && last_key == KEY_NONE) begin
      if (key == KEY_ENTER) begin
        r.verdict_valid = 1'b1;
      end else if (key == KEY_CLEAR) begin
        typed_count      = '0;
        typed_buf        = '0;
        r.buffer_cleared = 1'b1;
      end else begin
        if (typed_count < BUF_LEN) typed_buf[typed_count] = key;
        typed_count++;
        r.char_accepted = 1'b1;
        if (typed_count >= MAX_CHARS_DEF) r.verdict_valid = 1'b1;
      end
    end
    r.chars_entered = lock_entry ? typed_count : '0;
    if (r.verdict_valid) begin
      // All ten bytes take part, zero padding included.
      r.access_granted = (typed_buf == stored_password(lock_user));
      lock_entry  = 1'b0;
      typed_count = '0;
      typed_buf   = '0;
    end
    last_key      = key;
    r.entry_phase = lock_entry;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] typeable_char();
    logic [KEY_W-1:0] c;
    c = KEY_ENTER;
    while (c == KEY_ENTER || c == KEY_CLEAR) c = KEY_W'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic pass_t random_password();
    pass_t pw;
    int    len;
    pw  = '0;
    len = $urandom_range(0, BUF_LEN);
    for (int k = 0; k < len; k++) pw[k] = typeable_char();
    return pw;
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_key_code <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lock_results.push_back(lock_step(key));
    items_sent++;
  endtask

  // Releases the key first so that the press is seen as a new edge.
  task automatic press_key(input logic [KEY_W-1:0] key);
    repeat ($urandom_range(1, 2)) send_key(KEY_NONE);
    send_key(key);
    if ($urandom_range(0, 3) == 0) send_key(key);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lock_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lock_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    for (int u = 0; u < NUM_USERS; u++) begin
      if (idx == low_reg[u])  pass_low[u]  = val;
      if (idx == high_reg[u]) pass_high[u] = val[PASS_HI_W-1:0];
    end
  endtask

  task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    kpl_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lock_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none outstanding", results_seen);
      end else begin
        want = lock_results.pop_front();
        check_field("entry_phase", want.entry_phase, out_entry_phase);
        check_field("char_accepted", want.char_accepted, out_char_accepted);
        check_field("buffer_cleared", want.buffer_cleared, out_buffer_cleared);
        check_field("chars_entered", want.chars_entered, out_chars_entered);
        check_field("verdict_valid", want.verdict_valid, out_verdict_valid);
        check_field("access_granted", want.access_granted, out_access_granted);
      end
      results_seen++;
    end
  end

  // The receiver changes its stall behaviour every so often, including spells
  // with no stalls at all.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 8) < 3;
    endcase
  end

  // Default passwords: ignored login samples, the held selecting key, the clear
  // key, a granted entry, an enter with no release before it, a denied entry.
  task automatic test_login_and_clear();
    logic [KEY_W-1:0] keys [23] = '{
      8'hFF, KEY_W'(KEY_USER_LAST + 1), KEY_NONE,
      KEY_USER_FIRST, KEY_USER_FIRST, KEY_NONE, KEY_USER_FIRST, KEY_NONE,
      KEY_CLEAR, KEY_NONE, KEY_USER_FIRST, KEY_NONE, KEY_USER_FIRST, KEY_NONE,
      KEY_USER_FIRST, KEY_NONE, KEY_USER_FIRST, KEY_NONE, KEY_ENTER,
      KEY_USER_LAST, KEY_ENTER, KEY_NONE, KEY_ENTER};
    foreach (keys[i]) send_key(keys[i]);
    drain_results();
  endtask

  // A stored password with a zero byte before its last character must not
  // match the characters ahead of the zero. Also checks the masking of the
  // high register and that writes beyond the last register are dropped.
  task automatic test_inner_zero_password();
    logic [KEY_W-1:0] keys [7] = '{
      KEY_W'(KEY_USER_FIRST + 1), KEY_NONE, KEY_USER_FIRST, KEY_NONE,
      KEY_W'(KEY_USER_FIRST + 1), KEY_NONE, KEY_ENTER};
    // Characters "1", "2", zero, "3".
    write_lock_reg(REG_USER2_LOW, 64'h0000_0000_3300_3231);
    write_lock_reg(REG_USER2_HIGH, 64'hFFFF_FFFF_FFFF_0000);
    write_lock_reg(REG_OUT_OF_RANGE, '1);
    write_lock_reg(REG_INDEX_TOP, '0);
    foreach (keys[i]) send_key(keys[i]);
    drain_results();
  endtask

  // One login followed by an entry attempt of a randomly chosen kind.
  task automatic run_session();
    logic [USER_W-1:0] user;
    logic [KEY_W-1:0]  c;
    pass_t             pw;
    int                n;
    int                pos;
    int                kind;
    if ($urandom_range(0, 4) == 0) begin
      c = KEY_W'($urandom);
      if (c >= KEY_USER_FIRST && c <= KEY_USER_LAST) c = KEY_NONE;
      send_key(c);
    end
    user = USER_W'($urandom_range(0, NUM_USERS - 1));
    send_key(KEY_USER_FIRST + KEY_W'(user));
    repeat ($urandom_range(0, 2)) send_key(KEY_USER_FIRST + KEY_W'(user));
    pw = stored_password(user);
    n  = 0;
    while (n < BUF_LEN && pw[n] != KEY_NONE) n++;
    kind = $urandom_range(0, 9);
    if (kind == 6) begin
      repeat ($urandom_range(1, BUF_LEN)) press_key(typeable_char());
    end else if (kind == 9) begin
      // Raw noise: any byte, commands and zeros included.
      repeat ($urandom_range(1, 12)) send_key(KEY_W'($urandom));
    end else begin
      if (kind == 7 && n > 0) begin
        pos = $urandom_range(0, n - 1);
        c   = pw[pos];
        while (c == pw[pos]) c = typeable_char();
        pw[pos] = c;
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 3)) press_key(typeable_char());
        press_key(KEY_CLEAR);
      end
      for (int k = 0; k < n; k++) press_key(pw[k]);
    end
    while (lock_entry) press_key(KEY_ENTER);
  endtask

  task automatic test_random_sessions();
    int    start;
    int    target;
    bit    paused;
    pass_t pw;
    start  = items_sent;
    paused = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      for (int u = 0; u < NUM_USERS; u++) begin
        if (p == 0) begin
          pw = '1;
        end else if (p == 2) begin
          pw = '0;
        end else if ($urandom_range(0, 3) == 0) begin
          pw = (BUF_LEN * KEY_W)'({$urandom, $urandom, $urandom});
        end else begin
          pw = random_password();
        end
        write_lock_reg(low_reg[u], pw[7:0]);
        // Junk above bit 15 must be dropped by the high register.
        write_lock_reg(high_reg[u], {$urandom, 16'($urandom), pw[9:8]});
      end
      write_lock_reg(CFG_IDX_W'($urandom_range(REG_OUT_OF_RANGE, REG_INDEX_TOP)),
                     {$urandom, $urandom});
      target = start + (RANDOM_ITEMS * (p + 1)) / NUM_PHASES;
      while (items_sent < target) begin
        run_session();
        if (p == 3 && !paused && items_sent > target - RANDOM_ITEMS / 12) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_login_and_clear();
    test_inner_zero_password();
    test_random_sessions();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && lock_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
